[rtl/core/fir_filter_direct_form_macros.svh]
// assertion macros for the fir_filter_direct_form checker
// expects clk_i and rst_ni in the scope of use
`ifndef FIR_FILTER_DIRECT_FORM_MACROS_SVH
`define FIR_FILTER_DIRECT_FORM_MACROS_SVH

// property holds at every edge outside reset
`define FDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fir filter check failed");

// consequent holds in the cycle after the antecedent
`define FDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fir filter check failed");

`endif

[rtl/core/fdf_pkg.sv]
// types and constants shared by the fir filter modules
// no dependencies
`default_nettype none

package fdf_pkg;

  localparam int unsigned ACTION_BITS      = 2;
  localparam int unsigned COEFF_INDEX_BITS = 6;
  localparam int unsigned COEFF_BITS       = 16;
  localparam int unsigned FRAC_BITS        = 15;
  localparam int unsigned TAP_COUNT_BITS   = 7;
  localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 7'd64;

  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam logic REG_TAP_COUNT = 1'b0;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_FILTER = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

[rtl/core/fdf_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fdf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/fir_filter_direct_form.sv]
// fir_filter_direct_form: direct-form fir filter top level
// depends on fdf_pkg and fdf_ram
//
// Each filter word writes its sample into a circular delay line in ram and
// then runs one multiply-accumulate per active tap, one tap per cycle, reading
// the delay line ram and the coefficient ram in lockstep; the active taps are
// tap_count limited to 1..MAX_TAPS. After the last tap the drain state waits
// for the pipeline to empty; the sum goes to the result register once the
// previous result has been taken, and only then is the next word taken; the
// single shared multiplier and the one read port of each ram set this pace.
// Coefficient loads and unused action codes finish in the idle state. A clear
// word sweeps the delay line ram one entry a cycle. After reset a clearing
// pass zeroes both rams before the first word is taken. Register writes are
// taken at any time, but the tap count should change only while no filter
// word is in flight. The sum is floor-shifted right by 15 and saturated to
// SAMPLE_BITS.
`default_nettype none

module fir_filter_direct_form #(
  parameter int unsigned MAX_TAPS    = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [fdf_pkg::ACTION_BITS-1:0]       action_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in_i,
  input  logic [fdf_pkg::COEFF_INDEX_BITS-1:0]  coeff_index_i,
  input  logic signed [fdf_pkg::COEFF_BITS-1:0] coeff_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_out_o,
  output logic                                  saturated_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fdf_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [fdf_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [fdf_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                  pready
);
  import fdf_pkg::*;

  localparam int unsigned AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CW    = $clog2(MAX_TAPS + 1);
  localparam int unsigned CMPW  = ((TAP_COUNT_BITS > CW) ? TAP_COUNT_BITS : CW) + 1;
  localparam int unsigned IW    = ((COEFF_INDEX_BITS > AW) ? COEFF_INDEX_BITS : AW) + 1;
  localparam int unsigned PW    = SAMPLE_BITS + COEFF_BITS;
  localparam int unsigned ACC_W = PW + AW + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tap_addr_q, tap_addr_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic clr_coef_q, clr_coef_d;
  logic v1_q, v2_q, issue;
  logic signed [PW-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [TAP_COUNT_BITS-1:0] tap_count_q;
  logic out_valid_q, saturated_q, load_out;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;

  logic in_acc, last_tap, coef_idx_ok;
  logic [AW-1:0] head_inc, tap_prev;
  logic [CMPW-1:0] tc_ext;
  logic [CW-1:0] taps_eff;

  logic dl_we, cf_we;
  logic [AW-1:0] dl_waddr, cf_waddr;
  logic signed [SAMPLE_BITS-1:0] dl_wdata, dl_rdata;
  logic signed [COEFF_BITS-1:0] cf_wdata, cf_rdata;

  logic signed [ACC_W-1:0] shifted, res;
  logic sat_hi, sat_lo;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TAP_COUNT) ? APB_DATA_BITS'(tap_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TAP_COUNT) begin
      tap_count_q <= pwdata[TAP_COUNT_BITS-1:0];
    end
  end

  // effective tap count
  assign tc_ext = CMPW'(tap_count_q);
  always_comb begin
    if (tc_ext == '0) begin
      taps_eff = CW'(1);
    end else if (tc_ext > CMPW'(MAX_TAPS)) begin
      taps_eff = CW'(MAX_TAPS);
    end else begin
      taps_eff = tc_ext[CW-1:0];
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign head_inc    = (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + AW'(1);
  assign tap_prev    = (tap_addr_q == '0) ? AW'(MAX_TAPS - 1) : tap_addr_q - AW'(1);
  assign last_tap    = (CW'(k_q) + CW'(1)) == taps_eff;
  assign coef_idx_ok = IW'(coeff_index_i) < IW'(MAX_TAPS);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tap_addr_d = tap_addr_q;
    k_d        = k_q;
    clr_addr_d = clr_addr_q;
    clr_coef_d = clr_coef_q;
    acc_d      = v2_q ? acc_q + ACC_W'(prod_q) : acc_q;
    issue      = 1'b0;
    load_out   = 1'b0;
    dl_we      = 1'b0;
    dl_waddr   = head_q;
    dl_wdata   = sample_in_i;
    cf_we      = 1'b0;
    cf_waddr   = AW'(coeff_index_i);
    cf_wdata   = coeff_value_i;
    case (state_q)
      ST_CLEAR: begin
        dl_we    = 1'b1;
        dl_waddr = clr_addr_q;
        dl_wdata = '0;
        cf_we    = clr_coef_q;
        cf_waddr = clr_addr_q;
        cf_wdata = '0;
        if (clr_addr_q == AW'(MAX_TAPS - 1)) begin
          clr_coef_d = 1'b0;
          state_d    = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (action_e'(action_i))
            ACT_FILTER: begin
              dl_we      = 1'b1;
              dl_waddr   = head_inc;
              head_d     = head_inc;
              tap_addr_d = head_inc;
              k_d        = '0;
              acc_d      = '0;
              state_d    = ST_MAC;
            end
            ACT_LOAD: begin
              cf_we = coef_idx_ok;
            end
            ACT_CLEAR: begin
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        issue      = 1'b1;
        tap_addr_d = tap_prev;
        k_d        = k_q + AW'(1);
        if (last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      head_q      <= '0;
      clr_addr_q  <= '0;
      clr_coef_q  <= 1'b1;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      clr_addr_q <= clr_addr_d;
      clr_coef_q <= clr_coef_d;
      v1_q       <= issue;
      v2_q       <= v1_q;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tap_addr_q <= tap_addr_d;
    k_q        <= k_d;
    acc_q      <= acc_d;
    prod_q     <= dl_rdata * cf_rdata;
    if (load_out) begin
      sample_out_q <= res[SAMPLE_BITS-1:0];
      saturated_q  <= sat_hi || sat_lo;
    end
  end

  // floor shift and saturation
  assign shifted = acc_q >>> FRAC_BITS;
  assign sat_hi  = shifted > SAT_HI;
  assign sat_lo  = shifted < SAT_LO;
  assign res     = sat_hi ? SAT_HI : (sat_lo ? SAT_LO : shifted);

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign saturated_o  = saturated_q;

  fdf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_TAPS)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (dl_we),
    .waddr_i(dl_waddr),
    .wdata_i(dl_wdata),
    .raddr_i(tap_addr_q),
    .rdata_o(dl_rdata)
  );

  fdf_ram #(
    .WIDTH(COEFF_BITS),
    .DEPTH(MAX_TAPS)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (cf_we),
    .waddr_i(cf_waddr),
    .wdata_i(cf_wdata),
    .raddr_i(k_q),
    .rdata_o(cf_rdata)
  );

endmodule

`default_nettype wire

[rtl/core/fdf_checker.sv]
// port-level checks for fir_filter_direct_form, bound to the top level
// depends on fdf_pkg and fir_filter_direct_form_macros.svh
`default_nettype none
`include "fir_filter_direct_form_macros.svh"

module fdf_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [fdf_pkg::ACTION_BITS-1:0] action_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [SAMPLE_BITS-1:0]          sample_out_o,
  input logic                            saturated_o
);
  import fdf_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] MAX_OUT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MIN_OUT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // stalled word holds
  `FDF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(sample_out_o) && $stable(saturated_o))
  // only a filter word makes a result
  `FDF_ASSERT_NEXT(a_no_spurious, in_acc && action_i != ACT_FILTER && !out_valid_o, !out_valid_o)
  // a filter word keeps the block busy
  `FDF_ASSERT_NEXT(a_filter_busy, in_acc && action_i == ACT_FILTER, !in_ready_o)
  // clipped words sit at the rails
  `FDF_ASSERT(a_sat_rail, !(out_valid_o && saturated_o) || sample_out_o == MAX_OUT || sample_out_o == MIN_OUT)

endmodule

bind fir_filter_direct_form fdf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_fdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sample_out_o(sample_out_o),
  .saturated_o (saturated_o)
);

`default_nettype wire

[tb/fdf_response_checker.sv]
`timescale 1ns / 1ps
// fdf_response_checker: watches the word, result and apb channels of the fir filter,
// predicts every filtered sample and compares it with what comes out
// depends on fdf_pkg
module fdf_response_checker
  import fdf_pkg::*;
#(
  parameter int unsigned MAX_TAPS    = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [ACTION_BITS-1:0]         action_i,
  input  logic signed [SAMPLE_BITS-1:0]  sample_in_i,
  input  logic [COEFF_INDEX_BITS-1:0]    coeff_index_i,
  input  logic signed [COEFF_BITS-1:0]   coeff_value_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0]  sample_out_i,
  input  logic                           saturated_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [APB_ADDR_BITS-1:0]       paddr_i,
  input  logic [APB_DATA_BITS-1:0]       pwdata_i,
  input  logic                           pready_i,
  output int unsigned                    error_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o
);

  localparam logic [APB_ADDR_BITS-1:0] TAP_COUNT_ADDR = APB_ADDR_BITS'(4 * REG_TAP_COUNT);
  localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] level;
    logic                          clipped;
  } filtered_sample_t;

  filtered_sample_t              expected_samples[$];
  filtered_sample_t              oldest;
  logic signed [SAMPLE_BITS-1:0] delay_line[MAX_TAPS];
  logic signed [COEFF_BITS-1:0]  coeff_store[MAX_TAPS];
  logic [TAP_COUNT_BITS-1:0]     tap_setting;
  int unsigned                   errors;
  int unsigned                   compared;

  function automatic filtered_sample_t filter_sample(logic signed [SAMPLE_BITS-1:0] x);
    int unsigned      taps;
    int               i;
    longint           acc;
    filtered_sample_t r;
    taps = (tap_setting == 0) ? 1 : (tap_setting > MAX_TAPS) ? MAX_TAPS : tap_setting;
    for (i = MAX_TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
    delay_line[0] = x;
    acc = 0;
    for (i = 0; i < taps; i++) acc += longint'(coeff_store[i]) * longint'(delay_line[i]);
    // arithmetic shift floors toward minus infinity
    acc = acc >>> FRAC_BITS;
    r.clipped = 1'b1;
    if (acc > OUT_MAX) begin
      acc = OUT_MAX;
    end else if (acc < OUT_MIN) begin
      acc = OUT_MIN;
    end else begin
      r.clipped = 1'b0;
    end
    r.level = acc[SAMPLE_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_samples.delete();
      foreach (delay_line[i]) delay_line[i] = '0;
      foreach (coeff_store[i]) coeff_store[i] = '0;
      tap_setting = TAP_COUNT_RESET;
      errors = 0;
      compared = 0;
      error_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: sample_out %0d saturated %0b",
                   $time, sample_out_i, saturated_i);
        end else begin
          oldest = expected_samples.pop_front();
          compared++;
          if (oldest.level !== sample_out_i) begin
            errors++;
            $display("%0t: sample_out expected %0d, got %0d", $time, oldest.level, sample_out_i);
          end
          if (oldest.clipped !== saturated_i) begin
            errors++;
            $display("%0t: saturated expected %0b, got %0b", $time, oldest.clipped, saturated_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (action_i)
          ACT_FILTER: expected_samples.push_back(filter_sample(sample_in_i));
          ACT_LOAD: begin
            if (coeff_index_i < MAX_TAPS) coeff_store[coeff_index_i] = coeff_value_i;
          end
          ACT_CLEAR: begin
            foreach (delay_line[i]) delay_line[i] = '0;
          end
          default: ;
        endcase
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == TAP_COUNT_ADDR) begin
        tap_setting = pwdata_i[TAP_COUNT_BITS-1:0];
      end
      error_count_o <= errors;
      pending_o <= expected_samples.size();
      checked_o <= compared;
    end
  end

endmodule

[tb/tb_fir_filter_direct_form.sv]
`timescale 1ns / 1ps
// tb_fir_filter_direct_form: drives words and tap count writes into the fir filter
// under several idle patterns and reports the verdict
// depends on fdf_pkg, fir_filter_direct_form and fdf_response_checker
module tb_fir_filter_direct_form;
  import fdf_pkg::*;

  localparam int unsigned MAX_TAPS        = 64;
  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned WORDS_PER_PHASE = 128;
  localparam int unsigned SETTLE_CYCLES   = MAX_TAPS + 16;
  localparam int          RANDOM_TAPS     = -1;
  localparam logic [ACTION_BITS-1:0]   ACT_UNUSED     = 2'd3;
  localparam logic [APB_ADDR_BITS-1:0] TAP_COUNT_ADDR = APB_ADDR_BITS'(4 * REG_TAP_COUNT);
  localparam logic signed [SAMPLE_BITS-1:0] LEVEL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] LEVEL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ACTION_BITS-1:0]        action = ACT_FILTER;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic [COEFF_INDEX_BITS-1:0]   coeff_index = '0;
  logic signed [COEFF_BITS-1:0]  coeff_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0]      paddr = '0;
  logic [APB_DATA_BITS-1:0]      pwdata = '0;
  logic [APB_DATA_BITS-1:0]      prdata;
  logic                          pready;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned filter_words = 0;
  int unsigned load_words = 0;
  int unsigned clear_words = 0;
  int unsigned unused_words = 0;
  int          tap_plan[PHASES] = '{64, 1, 0, 127, 2, RANDOM_TAPS, RANDOM_TAPS, 16,
                                    RANDOM_TAPS, 65, 63, 64};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  fir_filter_direct_form #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .sample_in_i  (sample_in),
    .coeff_index_i(coeff_index),
    .coeff_value_i(coeff_value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out),
    .saturated_o  (saturated),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  fdf_response_checker #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .sample_in_i  (sample_in),
    .coeff_index_i(coeff_index),
    .coeff_value_i(coeff_value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_i (sample_out),
    .saturated_i  (saturated),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .error_count_o(error_count),
    .pending_o    (pending_count),
    .checked_o    (checked_count)
  );

  function automatic logic signed [SAMPLE_BITS-1:0] pick_level();
    case ($urandom_range(7))
      0:       return LEVEL_MAX;
      1:       return LEVEL_MIN;
      2, 3:    return SAMPLE_BITS'(int'($urandom_range(511)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic [ACTION_BITS-1:0] act,
                           input logic signed [SAMPLE_BITS-1:0] level,
                           input logic [COEFF_INDEX_BITS-1:0] idx,
                           input logic signed [COEFF_BITS-1:0] coeff);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    sample_in <= level;
    coeff_index <= idx;
    coeff_value <= coeff;
    do @(posedge clk); while (!in_ready);
    case (act)
      ACT_FILTER: filter_words++;
      ACT_LOAD:   load_words++;
      ACT_CLEAR:  clear_words++;
      default:    unused_words++;
    endcase
  endtask

  task automatic push_random_word(output bit counted);
    int unsigned            pick;
    logic [ACTION_BITS-1:0] act;
    pick = $urandom_range(99);
    if (pick < 68) begin
      act = ACT_FILTER;
    end else if (pick < 91) begin
      act = ACT_LOAD;
    end else if (pick < 96) begin
      act = ACT_CLEAR;
    end else begin
      act = ACT_UNUSED;
    end
    push_word(act, pick_level(), COEFF_INDEX_BITS'($urandom_range(MAX_TAPS - 1)),
              COEFF_BITS'(pick_level()));
    counted = (act != ACT_UNUSED);
  endtask

  // drop valid and hold off until every filtered sample has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_tap_count(input logic [TAP_COUNT_BITS-1:0] taps);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= TAP_COUNT_ADDR;
    pwdata <= APB_DATA_BITS'(taps);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned               counted_words;
    bit                        counted;
    logic [TAP_COUNT_BITS-1:0] taps;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_tap_count(TAP_COUNT_BITS'(MAX_TAPS));

    // all coefficients still zero
    push_word(ACT_FILTER, 16'sd100, '0, '0);
    push_word(ACT_LOAD, '0, 6'd0, LEVEL_MIN);
    push_word(ACT_LOAD, '0, 6'd1, LEVEL_MIN);
    push_word(ACT_LOAD, '0, 6'd63, LEVEL_MAX);
    // clip low, then clip high
    push_word(ACT_FILTER, LEVEL_MAX, '0, '0);
    push_word(ACT_FILTER, LEVEL_MAX, '0, '0);
    push_word(ACT_FILTER, LEVEL_MIN, '0, '0);
    push_word(ACT_FILTER, LEVEL_MIN, '0, '0);
    push_word(ACT_UNUSED, LEVEL_MAX, 6'd63, LEVEL_MAX);
    push_word(ACT_CLEAR, LEVEL_MIN, 6'd0, LEVEL_MIN);
    push_word(ACT_FILTER, -16'sd1, '0, '0);
    push_word(ACT_LOAD, '0, 6'd0, LEVEL_MAX);
    push_word(ACT_FILTER, 16'sd1, '0, '0);
    push_word(ACT_CLEAR, '0, '0, '0);
    // negative sum below one step floors to minus one
    push_word(ACT_FILTER, -16'sd1, '0, '0);
    push_word(ACT_FILTER, 16'sd0, '0, '0);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    for (int unsigned p = 0; p < PHASES; p++) begin
      taps = (tap_plan[p] == RANDOM_TAPS) ? TAP_COUNT_BITS'($urandom_range(127))
                                          : TAP_COUNT_BITS'(tap_plan[p]);
      write_tap_count(taps);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      counted_words = 0;
      while (counted_words < WORDS_PER_PHASE) begin
        if (p % 2 == 1 && counted_words == WORDS_PER_PHASE / 2) wait_for_results();
        push_random_word(counted);
        if (counted) counted_words++;
      end
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    $display("covered %0d words: %0d filter, %0d coefficient load, %0d clear, %0d unused",
             filter_words + load_words + clear_words + unused_words,
             filter_words, load_words, clear_words, unused_words);
    $display("%0d tap count settings from 0 to 127 under four idle patterns, %0d results compared",
             PHASES + 1, checked_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
